[src/olpr_pkg.sv]
// Shared types and constants for the ordered list with push and remove.
package olpr_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  // Input operation codes
  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  // Result status codes
  localparam logic [2:0] ST_DONE     = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_ELEM     = 3'd4;

  // What every cell does with its stored entry
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_REMOVE,
    CELL_ROTATE
  } cell_op_t;

  // Broadcast from the controller to every cell
  typedef struct packed {
    cell_op_t            op;
    logic [DATA_W-1:0]   value;
    logic [DATA_W-1:0]   head;
  } cell_ctrl_t;

endpackage

[src/olpr_cell.sv]
// One list cell: holds an entry and shifts it toward the front or the back.
module olpr_cell (
  input  logic                        clk,
  input  olpr_pkg::cell_ctrl_t        ctrl,
  input  logic                        live,
  input  logic                        tail,
  input  logic [olpr_pkg::DATA_W-1:0] prev_data,
  input  logic [olpr_pkg::DATA_W-1:0] next_data,
  input  logic                        found_in,
  output logic                        found_out,
  output logic [olpr_pkg::DATA_W-1:0] data
);
  import olpr_pkg::*;

  logic hit;

  // Compare the held entry with the search value
  assign hit       = live && (data == ctrl.value);
  assign found_out = found_in || hit;

  // Shift, close the gap, or rotate the stored entry
  always_ff @(posedge clk) begin
    case (ctrl.op)
      CELL_PUSH:   data <= prev_data;
      CELL_REMOVE: begin
        if (found_out) begin
          data <= next_data;
        end
      end
      CELL_ROTATE: data <= tail ? ctrl.head : next_data;
      default:     data <= data;
    endcase
  end

endmodule

[src/ordered_list_push_remove.sv]
// Ordered list of signed 32-bit values held in a chain of cells, front at cell 0.
// Push, remove and an unknown opcode each give one result beat. Entries hold no reset.
// A read out is accepted with no result beat, then gives one entry per cycle unless
// the output stalls: the chain rotates by one cell per beat and the front cell feeds
// the output register, so the list is back in place after the last beat. No new item
// is taken during a read out or while the output register is full and stalled.
module ordered_list_push_remove (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic signed [31:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic signed [31:0] element,
  output logic        last,
  output logic [4:0]  count
);
  import olpr_pkg::*;

  typedef enum logic {S_IDLE, S_READ} state_t;

  state_t            state;
  logic [CNT_W-1:0]  occ;
  logic [CNT_W-1:0]  remain;
  logic              out_free;
  logic              in_acc;
  logic              match_any;
  cell_ctrl_t        ctrl;
  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [CAPACITY:0] found;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state == S_READ) || !out_free;
  assign in_acc   = in_valid && !in_stall;

  // Pick the cell operation for this cycle
  always_comb begin
    ctrl.op    = CELL_HOLD;
    ctrl.value = value;
    ctrl.head  = cell_data[0];
    if (in_acc) begin
      case (opcode)
        OP_PUSH:   ctrl.op = (occ < CNT_W'(CAPACITY)) ? CELL_PUSH : CELL_HOLD;
        OP_REMOVE: ctrl.op = CELL_REMOVE;
        default:   ctrl.op = CELL_HOLD;
      endcase
    end else if (state == S_READ && out_free) begin
      ctrl.op = CELL_ROTATE;
    end
  end

  // Build the chain of cells
  assign found[0]  = 1'b0;
  assign match_any = found[CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] prev_d;
    logic [DATA_W-1:0] next_d;

    if (i == 0) begin : g_first
      assign prev_d = value;
    end else begin : g_mid
      assign prev_d = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_end
      assign next_d = cell_data[0];
    end else begin : g_nxt
      assign next_d = cell_data[i+1];
    end

    olpr_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .live      (occ > CNT_W'(i)),
      .tail      (occ == CNT_W'(i + 1)),
      .prev_data (prev_d),
      .next_data (next_d),
      .found_in  (found[i]),
      .found_out (found[i+1]),
      .data      (cell_data[i])
    );
  end

  // Hold state, occupancy and the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occ       <= '0;
      remain    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (in_acc) begin
        element <= '0;
        last    <= 1'b1;
        case (opcode)
          OP_PUSH: begin
            out_valid <= 1'b1;
            if (occ < CNT_W'(CAPACITY)) begin
              occ    <= occ + CNT_W'(1);
              status <= ST_DONE;
              count  <= 5'(occ + CNT_W'(1));
            end else begin
              status <= ST_FULL;
              count  <= 5'(occ);
            end
          end
          OP_REMOVE: begin
            out_valid <= 1'b1;
            if (match_any) begin
              occ    <= occ - CNT_W'(1);
              status <= ST_DONE;
              count  <= 5'(occ - CNT_W'(1));
            end else begin
              status <= ST_NOTFOUND;
              count  <= 5'(occ);
            end
          end
          OP_READ: begin
            if (occ == '0) begin
              out_valid <= 1'b1;
              status    <= ST_EMPTY;
              count     <= 5'(occ);
            end else begin
              state  <= S_READ;
              remain <= occ;
            end
          end
          default: begin
            out_valid <= 1'b1;
            status    <= ST_DONE;
            count     <= 5'(occ);
          end
        endcase
      end else if (state == S_READ && out_free) begin
        // Advance one entry per beat from the front cell
        out_valid <= 1'b1;
        status    <= ST_ELEM;
        element   <= cell_data[0];
        last      <= (remain == CNT_W'(1));
        count     <= 5'(occ);
        remain    <= remain - CNT_W'(1);
        if (remain == CNT_W'(1)) begin
          state <= S_IDLE;
        end
      end
    end
  end

  // Occupancy never passes the capacity
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CNT_W'(CAPACITY))
    else $error("occupancy above capacity");

  // A read out never runs with zero entries left
  a_read_remain: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (remain != '0))
    else $error("read out with nothing left");

  // A push into a list with room grows it by one
  a_push_grow: assert property (@(posedge clk) disable iff (rst)
    (in_acc && opcode == OP_PUSH && occ < CNT_W'(CAPACITY))
      |=> (occ == $past(occ) + CNT_W'(1)))
    else $error("push did not grow the list");

  // Non-element results carry a zero element
  a_elem_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_ELEM) |-> (element == '0))
    else $error("element set on a non-element result");

endmodule
